FILE: rtl/uv_sphere_mesh_generator_defines.svh
// ----------------------------------------------------------------------------
// uv sphere mesh generator assertion macros
// Shared check templates, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_DEFINES_SVH

// same-cycle implication
`define USMG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("usmg check failed");

// next-cycle implication
`define USMG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("usmg check failed");

`endif

FILE: rtl/usmg_pkg.sv
// ----------------------------------------------------------------------------
// usmg_pkg
// Constants, types and the quarter-wave sine table of the sphere generator.
// ----------------------------------------------------------------------------
package usmg_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 14;
  localparam int INDEX_BITS = 16;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
  localparam int QUO_BITS   = ANGLE_BITS + 1;
  localparam int CNT_BITS   = $clog2(ANGLE_BITS + 2);
  localparam int DIV_P_LAST = ANGLE_BITS - 1;
  localparam int DIV_T_LAST = ANGLE_BITS;
  localparam int LOOK_LAST  = 4;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // walk phases
  localparam logic [2:0] PH_NORTH  = 3'd0;
  localparam logic [2:0] PH_RING   = 3'd1;
  localparam logic [2:0] PH_SOUTH  = 3'd2;
  localparam logic [2:0] PH_TOP    = 3'd3;
  localparam logic [2:0] PH_QUAD   = 3'd4;
  localparam logic [2:0] PH_BOTTOM = 3'd5;

  typedef enum logic [1:0] {
    MUL_RING,
    MUL_SOUTH,
    MUL_X,
    MUL_Z
  } mul_sel_e;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] ring;
    logic [8:0] slice;
    logic       second;
    logic       last;
  } elem_t;

  typedef struct packed {
    logic     div_load;
    logic     div_t;
    logic     div_step;
    logic     div_first;
    logic     ang_p_we;
    logic     ang_t_we;
    logic     lk_vld;
    logic [1:0] lk_sel;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     x_we;
    logic     out_load;
    elem_t    elem;
  } cmd_t;

  typedef struct packed {
    logic                         kind;
    logic signed [15:0]           pos_x;
    logic signed [15:0]           pos_y;
    logic signed [15:0]           pos_z;
    logic [INDEX_BITS-1:0]        corner_a;
    logic [INDEX_BITS-1:0]        corner_b;
    logic [INDEX_BITS-1:0]        corner_c;
    logic                         last;
  } out_t;

  typedef logic [FRAC_BITS:0] sin_rom_t [0:QUARTER];

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // term of the taylor series divided by (2n)(2n+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
    logic [63:0] r;
    case (n)
      1:       r = t / 64'd6;
      2:       r = t / 64'd20;
      3:       r = t / 64'd42;
      4:       r = t / 64'd72;
      5:       r = t / 64'd110;
      6:       r = t / 64'd156;
      7:       r = t / 64'd210;
      8:       r = t / 64'd272;
      9:       r = t / 64'd342;
      10:      r = t / 64'd420;
      11:      r = t / 64'd506;
      12:      r = t / 64'd600;
      default: r = t / 64'd702;
    endcase
    return r;
  endfunction

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t    rom;
    logic [63:0] step_x;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    step_x = PI_Q62 >> (ANGLE_BITS - 1);
    for (int r = 0; r <= QUARTER; r++) begin
      x  = step_x * 64'(r);
      x2 = qmul(x, x);
      t  = x;
      s  = x;
      for (int n = 1; n <= 13; n++) begin
        t = taylor_div(qmul(t, x2), n);
        if (n[0]) begin
          s = s - t;
        end else begin
          s = s + t;
        end
      end
      rom[r] = (FRAC_BITS + 1)'((s + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

FILE: rtl/usmg_stream_if.sv
// ----------------------------------------------------------------------------
// usmg stream interfaces
// Valid/ready channels for restart beats in and mesh elements out.
// ----------------------------------------------------------------------------
interface usmg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface usmg_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] corner_a;
  logic [15:0] corner_b;
  logic [15:0] corner_c;
  logic        last;
  modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
                  output corner_a, output corner_b, output corner_c, output last,
                  input ready);
  modport sink (input valid, input kind, input pos_x, input pos_y, input pos_z,
                input corner_a, input corner_b, input corner_c, input last,
                output ready);
endinterface

FILE: rtl/usmg_ctrl.sv
// ----------------------------------------------------------------------------
// usmg_ctrl
// Mesh walk state and the sequencer that drives the datapath per element.
// ----------------------------------------------------------------------------
module usmg_ctrl import usmg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] stacks_i,
  input  logic [7:0] slices_i,
  input  logic       in_valid_i,
  input  logic       in_restart_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_IMUL = 4'd1;
  localparam logic [3:0] S_LDP  = 4'd2;
  localparam logic [3:0] S_DIVP = 4'd3;
  localparam logic [3:0] S_LDT  = 4'd4;
  localparam logic [3:0] S_DIVT = 4'd5;
  localparam logic [3:0] S_LOOK = 4'd6;
  localparam logic [3:0] S_MULX = 4'd7;
  localparam logic [3:0] S_MULZ = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [2:0]          ph_q, ph_d;
  logic [7:0]          ring_q, ring_d;
  logic [8:0]          slc_q, slc_d;
  logic                sec_q, sec_d;
  elem_t               cur_q, cur_d;
  logic                out_valid_q, out_valid_d;

  logic [2:0] ph;
  logic [7:0] ri;
  logic [8:0] sj;
  logic       sc;
  logic       ok;
  logic [8:0] j1;
  logic [8:0] i1;
  logic [8:0] sl9;
  logic       lst;
  logic       accept;

  assign sl9    = {1'b0, slices_i};
  assign accept = in_valid_i && (state_q == S_IDLE);

  // current element after restart and range check
  always_comb begin
    ph = ph_q;
    ri = ring_q;
    sj = slc_q;
    sc = sec_q;
    if (in_restart_i) begin
      ph = PH_NORTH;
      ri = '0;
      sj = '0;
      sc = 1'b0;
    end
    unique case (ph) inside
      PH_NORTH, PH_SOUTH: ok = 1'b1;
      PH_RING:   ok = (ri >= 8'd1) && (ri < stacks_i) && (sj <= sl9);
      PH_TOP:    ok = (sj >= 9'd1) && (sj <= sl9);
      PH_QUAD:   ok = (stacks_i > 8'd2) && (ri <= stacks_i - 8'd3) && (sj < sl9);
      PH_BOTTOM: ok = sj < sl9;
      default:   ok = 1'b0;
    endcase
    if (!ok) begin
      ph = PH_NORTH;
      ri = '0;
      sj = '0;
      sc = 1'b0;
    end
  end

  assign j1  = sj + 9'd1;
  assign i1  = {1'b0, ri} + 9'd1;
  assign lst = (ph == PH_BOTTOM) && (j1 >= sl9);

  // next walk position
  always_comb begin
    ph_d   = ph;
    ring_d = ri;
    slc_d  = sj;
    sec_d  = sc;
    unique case (ph)
      PH_NORTH: begin
        ph_d   = PH_RING;
        ring_d = 8'd1;
        slc_d  = '0;
      end
      PH_RING: begin
        slc_d = j1;
        if (j1 > sl9) begin
          slc_d  = '0;
          ring_d = i1[7:0];
          if (i1 >= {1'b0, stacks_i}) begin
            ph_d   = PH_SOUTH;
            ring_d = '0;
          end
        end
      end
      PH_SOUTH: begin
        ph_d  = PH_TOP;
        slc_d = 9'd1;
      end
      PH_TOP: begin
        slc_d = j1;
        if (j1 > sl9) begin
          slc_d  = '0;
          ring_d = '0;
          sec_d  = 1'b0;
          ph_d   = (stacks_i > 8'd2) ? PH_QUAD : PH_BOTTOM;
        end
      end
      PH_QUAD: begin
        if (!sc) begin
          sec_d = 1'b1;
        end else begin
          sec_d = 1'b0;
          slc_d = j1;
          if (j1 >= sl9) begin
            slc_d  = '0;
            ring_d = i1[7:0];
            if (i1 > {1'b0, stacks_i - 8'd3}) begin
              ph_d   = PH_BOTTOM;
              ring_d = '0;
            end
          end
        end
      end
      default: begin
        slc_d = j1;
        if (lst) begin
          ph_d   = PH_NORTH;
          ring_d = '0;
          slc_d  = '0;
          sec_d  = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cur_d = '{phase: ph, ring: ri, slice: sj, second: sc, last: lst};
          if (ph == PH_RING) begin
            state_d = S_LDP;
          end else if (ph == PH_QUAD || ph == PH_BOTTOM) begin
            state_d = S_IMUL;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_IMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = (cur_q.phase == PH_QUAD) ? MUL_RING : MUL_SOUTH;
        state_d       = S_OUT;
      end
      S_LDP: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIVP;
      end
      S_DIVP: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(DIV_P_LAST)) begin
          state_d = S_LDT;
        end
      end
      S_LDT: begin
        cmd_o.ang_p_we = 1'b1;
        cmd_o.div_load = 1'b1;
        cmd_o.div_t    = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIVT;
      end
      S_DIVT: begin
        cmd_o.div_t     = 1'b1;
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(DIV_T_LAST)) begin
          cnt_d   = '0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        // four table reads; the state holds on until the last one has passed rom_q into trig_q
        cmd_o.ang_t_we = (cnt_q == '0);
        cmd_o.lk_vld   = (cnt_q < CNT_BITS'(LOOK_LAST));
        cmd_o.lk_sel   = cnt_q[1:0];
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(LOOK_LAST)) begin
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X;
        state_d       = S_MULZ;
      end
      S_MULZ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Z;
        cmd_o.x_we    = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.elem = cur_q;
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ph_q        <= PH_NORTH;
      ring_q      <= '0;
      slc_q       <= '0;
      sec_q       <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        ph_q   <= ph_d;
        ring_q <= ring_d;
        slc_q  <= slc_d;
        sec_q  <= sec_d;
      end
    end
  end

endmodule

FILE: rtl/usmg_dp.sv
// ----------------------------------------------------------------------------
// usmg_dp
// Angle divider, sine table, shared multiplier and the output register.
// ----------------------------------------------------------------------------
module usmg_dp import usmg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] stacks_i,
  input  logic [7:0] slices_i,
  input  cmd_t       cmd_i,
  output out_t       out_o
);

  logic [8:0]            rv;
  logic [8:0]            rem_q;
  logic [QUO_BITS-1:0]   quo_q;
  logic [8:0]            div_tmp;
  logic [8:0]            divisor;
  logic                  div_ge;
  logic [ANGLE_BITS-1:0] ang_p_q;
  logic [ANGLE_BITS-1:0] ang_t_q;
  logic [ANGLE_BITS-1:0] code;
  logic [ANGLE_BITS-3:0] code_r;
  logic [ANGLE_BITS-2:0] rom_idx;
  logic [FRAC_BITS:0]    rom_q;
  logic                  lk_neg_q;
  logic [1:0]            lk_sel_q;
  logic                  lk_vld_q;
  logic signed [15:0]    trig_val;
  logic signed [15:0]    trig_q [0:3];
  logic signed [15:0]    mul_a;
  logic signed [15:0]    mul_b;
  logic signed [31:0]    mul_q;
  logic signed [31:0]    mul_sh;
  logic signed [15:0]    x_q;
  logic [INDEX_BITS-1:0] base1;
  logic [INDEX_BITS-1:0] tr;
  logic [INDEX_BITS-1:0] br;
  logic [INDEX_BITS-1:0] bot;
  logic [INDEX_BITS-1:0] jx;
  logic [INDEX_BITS-1:0] rvx;
  out_t                  res;
  out_t                  out_q;

  assign rv = {1'b0, slices_i} + 9'd1;

  // restoring divider, first step compares the loaded value unshifted
  assign divisor = cmd_i.div_t ? {1'b0, slices_i} : {1'b0, stacks_i};
  assign div_tmp = cmd_i.div_first ? rem_q : {rem_q[7:0], 1'b0};
  assign div_ge  = div_tmp >= divisor;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= cmd_i.div_t ? cmd_i.elem.slice : {1'b0, cmd_i.elem.ring};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_tmp - divisor : div_tmp;
      quo_q <= {quo_q[QUO_BITS-2:0], div_ge};
    end
    if (cmd_i.ang_p_we) begin
      ang_p_q <= quo_q[ANGLE_BITS-1:0];
    end
    if (cmd_i.ang_t_we) begin
      ang_t_q <= quo_q[ANGLE_BITS-1:0];
    end
  end

  // quadrant fold onto the quarter-wave table
  always_comb begin
    code = cmd_i.lk_sel[1] ? ang_t_q : ang_p_q;
    if (cmd_i.lk_sel[0]) begin
      code = code + ANGLE_BITS'(QUARTER);
    end
    code_r  = code[ANGLE_BITS-3:0];
    rom_idx = code[ANGLE_BITS-2] ? (ANGLE_BITS - 1)'(QUARTER) - {1'b0, code_r}
                                 : {1'b0, code_r};
  end

  always_ff @(posedge clk_i) begin
    rom_q    <= SIN_ROM[rom_idx];
    lk_neg_q <= code[ANGLE_BITS-1];
    lk_sel_q <= cmd_i.lk_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_vld_q <= 1'b0;
    end else begin
      lk_vld_q <= cmd_i.lk_vld;
    end
  end

  assign trig_val = lk_neg_q ? -$signed(16'(rom_q)) : $signed(16'(rom_q));

  always_ff @(posedge clk_i) begin
    if (lk_vld_q) begin
      trig_q[lk_sel_q] <= trig_val;
    end
  end

  // one shared multiplier: sin/cos products and vertex index bases
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RING: begin
        mul_a = $signed(16'(cmd_i.elem.ring));
        mul_b = $signed(16'(rv));
      end
      MUL_SOUTH: begin
        mul_a = $signed(16'(stacks_i - 8'd1));
        mul_b = $signed(16'(rv));
      end
      MUL_X: begin
        mul_a = trig_q[0];
        mul_b = trig_q[3];
      end
      default: begin
        mul_a = trig_q[0];
        mul_b = trig_q[2];
      end
    endcase
  end

  assign mul_sh = mul_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    if (cmd_i.x_we) begin
      x_q <= mul_sh[15:0];
    end
  end

  assign jx    = INDEX_BITS'(cmd_i.elem.slice);
  assign rvx   = INDEX_BITS'(rv);
  assign base1 = INDEX_BITS'(mul_q[15:0]) + INDEX_BITS'(1);
  assign tr    = base1 + jx;
  assign br    = tr + rvx;
  assign bot   = base1 - rvx + jx;

  always_comb begin
    res = '0;
    unique case (cmd_i.elem.phase)
      PH_NORTH: res.pos_y = 16'sd1 <<< FRAC_BITS;
      PH_SOUTH: res.pos_y = -(16'sd1 <<< FRAC_BITS);
      PH_RING: begin
        res.pos_x = x_q;
        res.pos_y = trig_q[1];
        res.pos_z = mul_sh[15:0];
      end
      PH_TOP: begin
        res.kind     = 1'b1;
        res.corner_b = jx + INDEX_BITS'(1);
        res.corner_c = jx;
      end
      PH_QUAD: begin
        res.kind     = 1'b1;
        res.corner_a = tr;
        if (!cmd_i.elem.second) begin
          res.corner_b = br;
          res.corner_c = br + INDEX_BITS'(1);
        end else begin
          res.corner_b = br + INDEX_BITS'(1);
          res.corner_c = tr + INDEX_BITS'(1);
        end
      end
      default: begin
        res.kind     = 1'b1;
        res.corner_a = base1;
        res.corner_b = bot;
        res.corner_c = bot + INDEX_BITS'(1);
        res.last     = cmd_i.elem.last;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  assign out_o = out_q;

endmodule

FILE: rtl/uv_sphere_mesh_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// Streams vertices then triangles of a UV sphere, one element per input beat.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   restart
//   out_o    out  valid/ready   kind, pos_x/y/z, corner_a/b/c, last
//   apb      in   psel/penable  stack_count @0x0, slice_count @0x4
//
// poles and top triangles go from accept straight to S_OUT; quad and bottom
// triangles pass S_IMUL first. a ring vertex runs two radix-2 angle divisions
// of 12 and 13 steps, four reads of the registered sine table and two products
// on the single multiplier. input is taken only when the sequencer is idle; a beat
// waiting on out_o does not hold up the next accept, only the next load.
// reset returns to the north pole with 16 stacks and 32 slices.
// ----------------------------------------------------------------------------
`include "uv_sphere_mesh_generator_defines.svh"

module uv_sphere_mesh_generator import usmg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  usmg_in_if.sink     in_i,
  usmg_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] stack_q;
  logic [7:0] slice_q;
  logic [7:0] stacks;
  logic [7:0] slices;
  logic       cfg_we;
  logic       no_corners;
  cmd_t       cmd;
  out_t       res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = 32'(paddr[2] ? slice_q : stack_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q <= 8'd16;
      slice_q <= 8'd32;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        slice_q <= pwdata[7:0];
      end else begin
        stack_q <= pwdata[7:0];
      end
    end
  end

  assign stacks = (stack_q < 8'd2) ? 8'd2 : stack_q;
  assign slices = (slice_q < 8'd3) ? 8'd3 : slice_q;

  usmg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stacks_i     (stacks),
    .slices_i     (slices),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_i.ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .cmd_o        (cmd)
  );

  usmg_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stacks_i (stacks),
    .slices_i (slices),
    .cmd_i    (cmd),
    .out_o    (res)
  );

  assign out_o.kind     = res.kind;
  assign out_o.pos_x    = res.pos_x;
  assign out_o.pos_y    = res.pos_y;
  assign out_o.pos_z    = res.pos_z;
  assign out_o.corner_a = res.corner_a;
  assign out_o.corner_b = res.corner_b;
  assign out_o.corner_c = res.corner_c;
  assign out_o.last     = res.last;

  assign no_corners = (out_o.corner_a | out_o.corner_b | out_o.corner_c) == 16'd0;

  // one element in flight at a time
  `USMG_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `USMG_ASSERT_NOW(a_last_is_triangle, out_o.valid && out_o.last, out_o.kind)
  `USMG_ASSERT_NOW(a_vertex_no_corners, out_o.valid && !out_o.kind, no_corners)

endmodule
